// ===== src/fsn_pkg.sv =====
// Package for the fractal simplex noise block: fixed-point constants, state
// and register codes, and the small helper functions shared by the design.
// No dependencies.
package fsn_pkg;

  localparam int unsigned MAX_OCTAVES = 8;
  localparam int unsigned PERM_DEPTH = 256;
  localparam int unsigned PERM_W = 8;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned DW = 20;
  localparam int unsigned SUM_W = 60;
  localparam int unsigned AMP_W = 31;
  localparam int unsigned AMPS_W = 32;

  localparam logic [15:0] F2_Q16 = 16'd23987;
  localparam logic [14:0] G2_Q16 = 15'd13849;
  localparam logic signed [DW-1:0] ONE_D = 20'sd65536;
  localparam logic signed [DW-1:0] G2_D = 20'sd13849;
  localparam logic signed [DW-1:0] G2X2_D = 20'sd27698;
  localparam logic [AMP_W-1:0] AMP_ONE = 31'd16384;
  localparam logic [3:0] OCT_MAX = 4'(MAX_OCTAVES);
  localparam logic [3:0] DIV_LAST = 4'd14;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OCTAVES   = 2'd0,
    CFG_LACUNARITY = 2'd1,
    CFG_GAIN      = 2'd2
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SKEW, ST_CELL, ST_OFFS, ST_CORN,
    ST_RD_A, ST_RD_B, ST_RD_C, ST_RD_D, ST_RD_E, ST_RD_F,
    ST_SQ, ST_TT, ST_T4, ST_CON,
    ST_NOISE, ST_ACC, ST_SUMS,
    ST_DIV_INIT, ST_DIV, ST_FIN
  } state_e;

  // Remainder of a byte by twelve through a reciprocal multiply.
  function automatic logic [3:0] mod12(input logic [7:0] v);
    logic [15:0] p;
    logic [7:0] qt;
    logic [7:0] r;
    p = 16'(v) * 16'd171;
    qt = {3'b000, p[15:11]};
    r = v - 8'(qt * 8'd12);
    return r[3:0];
  endfunction

  // Dot product of the gradient selected by g with the corner offset.
  function automatic logic signed [DW:0] gdot(input logic [3:0] g,
                                               input logic signed [DW-1:0] dx,
                                               input logic signed [DW-1:0] dy);
    logic signed [DW:0] ex;
    logic signed [DW:0] ey;
    logic signed [DW:0] r;
    ex = {dx[DW-1], dx};
    ey = {dy[DW-1], dy};
    case (g) inside
      4'd0: r = ex + ey;
      4'd1: r = ey - ex;
      4'd2: r = ex - ey;
      4'd3: r = -ex - ey;
      4'd4, 4'd6: r = ex;
      4'd5, 4'd7: r = -ex;
      4'd8, 4'd10: r = ey;
      4'd9, 4'd11: r = -ey;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/fsn_ram.sv =====
// Generic single-port RAM whose read data is registered.
// Holds the permutation table; no dependencies.
module fsn_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/fractal_simplex_noise_2d.sv =====
// Top level of the fractal 2D simplex noise block: octave sequencer, corner
// arithmetic, amplitude weighting and the final restoring divider.
// Depends on fsn_pkg and fsn_ram.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid_i, in_stall_o, mode_i, fields    | consumed
//   out     | out_valid_o, out_stall_i, noise_value_o   | produced
//   cfg     | cfg_we_i, cfg_idx_i, cfg_data_i           | written
//
// A load item writes one table entry. An evaluate item runs each octave through
// the skew, cell, offset, corner, table-read, per-corner and summing steps around
// the single table port and the shared multipliers; the division then yields a
// 15-bit quotient, one bit per step. With no octaves it goes straight to the end.
// Reset sets only the control and config registers; the table is undefined.
// A result waits in the output register while the next item is accepted.
module fractal_simplex_noise_2d import fsn_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  mode_i,
  input  logic [7:0]            table_index_i,
  input  logic [7:0]            table_value_i,
  input  logic signed [31:0]    point_x_i,
  input  logic signed [31:0]    point_y_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [15:0]    noise_value_o
);

  state_e state_q, state_d;

  logic [3:0]  oct_q;
  logic [15:0] lac_q, gain_q;
  logic [3:0]  k_q, n_q, dcnt_q;
  logic [1:0]  cidx_q;
  logic        out_valid_q;
  logic signed [15:0] out_q;

  logic signed [31:0] px_q, py_q, skew_q;
  logic signed [17:0] ci_q, cj_q;
  logic signed [DW-1:0] x0_q, y0_q, x1_q, y1_q, x2_q, y2_q;
  logic        i1_q;
  logic [7:0]  p0_q, p1_q, p2_q;
  logic [3:0]  g0_q, g1_q, g2_q;
  logic [23:0] sqx_q, sqy_q;
  logic        tneg_q;
  logic [14:0] t2_q;
  logic [12:0] t4_q;
  logic signed [36:0] acc_q;
  logic signed [22:0] noise_q;
  logic signed [53:0] prod_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [AMP_W-1:0]  amp_q;
  logic [AMPS_W-1:0] amps_q;
  logic [SUM_W-1:0]  rem_q;
  logic [45:0] dsh_q;
  logic [14:0] quo_q;
  logic        neg_q, sat_q;

  logic        ram_we;
  logic [7:0]  ram_addr, ram_wdata, ram_rdata;
  logic        accept, out_free;
  logic [3:0]  oct_n;

  logic signed [32:0] xy_sum;
  logic signed [49:0] skew_prod;
  logic signed [33:0] xs_sum, ys_sum;
  logic signed [18:0] ij_sum;
  logic signed [34:0] unskew;
  logic signed [35:0] x0_full, y0_full;
  logic signed [DW-1:0] dx_sel, dy_sel;
  logic [3:0]  g_sel;
  logic signed [39:0] sqx_prod, sqy_prod;
  logic signed [25:0] t_val;
  logic [31:0] t_sq;
  logic [29:0] t2_sq;
  logic signed [DW:0] dot;
  logic signed [34:0] contrib;
  logic signed [44:0] n70;
  logic signed [54:0] nprod;
  logic [46:0] amp_prod;
  logic signed [48:0] xl_prod, yl_prod;
  logic [SUM_W-1:0] abs_sum;
  logic signed [15:0] res;

  fsn_ram #(
    .Width(PERM_W),
    .Depth(PERM_DEPTH)
  ) u_perm (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign oct_n = (oct_q > OCT_MAX) ? OCT_MAX : oct_q;

  always_comb begin
    xy_sum = {px_q[31], px_q} + {py_q[31], py_q};
    skew_prod = xy_sum * $signed({1'b0, F2_Q16});
    xs_sum = {{2{px_q[31]}}, px_q} + {{2{skew_q[31]}}, skew_q};
    ys_sum = {{2{py_q[31]}}, py_q} + {{2{skew_q[31]}}, skew_q};
    ij_sum = {ci_q[17], ci_q} + {cj_q[17], cj_q};
    unskew = ij_sum * $signed({1'b0, G2_Q16});
    x0_full = {{4{px_q[31]}}, px_q} - {{2{ci_q[17]}}, ci_q, 16'd0}
              + {unskew[34], unskew};
    y0_full = {{4{py_q[31]}}, py_q} - {{2{cj_q[17]}}, cj_q, 16'd0}
              + {unskew[34], unskew};
    case (cidx_q)
      2'd0: begin
        dx_sel = x0_q;
        dy_sel = y0_q;
        g_sel = g0_q;
      end
      2'd1: begin
        dx_sel = x1_q;
        dy_sel = y1_q;
        g_sel = g1_q;
      end
      default: begin
        dx_sel = x2_q;
        dy_sel = y2_q;
        g_sel = g2_q;
      end
    endcase
    sqx_prod = dx_sel * dx_sel;
    sqy_prod = dy_sel * dy_sel;
    t_val = 26'sd32768 - $signed({2'b00, sqx_q}) - $signed({2'b00, sqy_q});
    t_sq = 32'(t_val[15:0]) * 32'(t_val[15:0]);
    t2_sq = 30'(t2_q) * 30'(t2_q);
    dot = gdot(g_sel, dx_sel, dy_sel);
    contrib = $signed({1'b0, t4_q}) * dot;
    n70 = acc_q * $signed(8'sd70);
    nprod = noise_q * $signed({1'b0, amp_q});
    amp_prod = 47'(amp_q) * 47'(gain_q);
    xl_prod = px_q * $signed({1'b0, lac_q});
    yl_prod = py_q * $signed({1'b0, lac_q});
    abs_sum = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
    if (sat_q) begin
      res = neg_q ? -16'sd32768 : 16'sd32767;
    end else begin
      res = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (mode_i == MODE_EVAL)) begin
          state_d = (oct_n == 4'd0) ? ST_FIN : ST_SKEW;
        end
      end
      ST_SKEW:  state_d = ST_CELL;
      ST_CELL:  state_d = ST_OFFS;
      ST_OFFS:  state_d = ST_CORN;
      ST_CORN:  state_d = ST_RD_A;
      ST_RD_A:  state_d = ST_RD_B;
      ST_RD_B:  state_d = ST_RD_C;
      ST_RD_C:  state_d = ST_RD_D;
      ST_RD_D:  state_d = ST_RD_E;
      ST_RD_E:  state_d = ST_RD_F;
      ST_RD_F:  state_d = ST_SQ;
      ST_SQ:    state_d = ST_TT;
      ST_TT:    state_d = ST_T4;
      ST_T4:    state_d = ST_CON;
      ST_CON:   state_d = (cidx_q == 2'd2) ? ST_NOISE : ST_SQ;
      ST_NOISE: state_d = ST_ACC;
      ST_ACC:   state_d = ST_SUMS;
      ST_SUMS:  state_d = (k_q + 4'd1 == n_q) ? ST_DIV_INIT : ST_SKEW;
      ST_DIV_INIT: state_d = ST_DIV;
      ST_DIV:   state_d = (dcnt_q == 4'd0) ? ST_FIN : ST_DIV;
      ST_FIN:   state_d = out_free ? ST_IDLE : ST_FIN;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    ram_we = 1'b0;
    ram_wdata = table_value_i;
    ram_addr = table_index_i;
    unique case (state_q)
      ST_IDLE: ram_we = accept && (mode_i == MODE_LOAD);
      ST_CORN: ram_addr = cj_q[7:0];
      ST_RD_A: ram_addr = cj_q[7:0] + {7'd0, ~i1_q};
      ST_RD_B: ram_addr = cj_q[7:0] + 8'd1;
      ST_RD_C: ram_addr = ci_q[7:0] + p0_q;
      ST_RD_D: ram_addr = ci_q[7:0] + {7'd0, i1_q} + p1_q;
      ST_RD_E: ram_addr = ci_q[7:0] + 8'd1 + p2_q;
      default: ram_addr = table_index_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      oct_q <= 4'd1;
      lac_q <= 16'd8192;
      gain_q <= 16'd8192;
      k_q <= '0;
      n_q <= '0;
      cidx_q <= '0;
      dcnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_OCTAVES:    oct_q <= cfg_data_i[3:0];
          CFG_LACUNARITY: lac_q <= cfg_data_i;
          CFG_GAIN:       gain_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        k_q <= '0;
        n_q <= oct_n;
      end
      if (state_q == ST_SKEW) begin
        cidx_q <= '0;
      end
      if (state_q == ST_CON) begin
        cidx_q <= cidx_q + 2'd1;
      end
      if (state_q == ST_SUMS) begin
        k_q <= k_q + 4'd1;
      end
      if (state_q == ST_DIV_INIT) begin
        dcnt_q <= DIV_LAST;
      end
      if (state_q == ST_DIV) begin
        dcnt_q <= dcnt_q - 4'd1;
      end
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        px_q <= point_x_i;
        py_q <= point_y_i;
        sum_q <= '0;
        amps_q <= '0;
        amp_q <= AMP_ONE;
        neg_q <= 1'b0;
        sat_q <= 1'b0;
        quo_q <= '0;
      end
      ST_SKEW: begin
        skew_q <= skew_prod[47:16];
        acc_q <= '0;
      end
      ST_CELL: begin
        ci_q <= xs_sum[33:16];
        cj_q <= ys_sum[33:16];
      end
      ST_OFFS: begin
        x0_q <= x0_full[DW-1:0];
        y0_q <= y0_full[DW-1:0];
      end
      ST_CORN: begin
        i1_q <= (x0_q > y0_q);
        x1_q <= x0_q - ((x0_q > y0_q) ? ONE_D : '0) + G2_D;
        y1_q <= y0_q - ((x0_q > y0_q) ? '0 : ONE_D) + G2_D;
        x2_q <= x0_q - ONE_D + G2X2_D;
        y2_q <= y0_q - ONE_D + G2X2_D;
      end
      ST_RD_A: begin
        p0_q <= ram_rdata;
        px_q <= xl_prod[43:12];
      end
      ST_RD_B: begin
        p1_q <= ram_rdata;
        py_q <= yl_prod[43:12];
      end
      ST_RD_C: p2_q <= ram_rdata;
      ST_RD_D: g0_q <= mod12(ram_rdata);
      ST_RD_E: g1_q <= mod12(ram_rdata);
      ST_RD_F: g2_q <= mod12(ram_rdata);
      ST_SQ: begin
        sqx_q <= sqx_prod[39:16];
        sqy_q <= sqy_prod[39:16];
      end
      ST_TT: begin
        tneg_q <= t_val[25];
        t2_q <= t_sq[30:16];
      end
      ST_T4: t4_q <= t2_sq[28:16];
      ST_CON: begin
        if (!tneg_q) begin
          acc_q <= acc_q + {{2{contrib[34]}}, contrib};
        end
      end
      ST_NOISE: noise_q <= n70[39:17];
      ST_ACC: prod_q <= nprod[53:0];
      ST_SUMS: begin
        sum_q <= sum_q + {{(SUM_W-54){prod_q[53]}}, prod_q};
        amps_q <= amps_q + AMPS_W'(amp_q);
        amp_q <= amp_prod[44:14];
      end
      ST_DIV_INIT: begin
        neg_q <= sum_q[SUM_W-1];
        rem_q <= abs_sum;
        sat_q <= (abs_sum >= {13'd0, amps_q, 15'd0});
        dsh_q <= {amps_q, 14'd0};
        quo_q <= '0;
      end
      ST_DIV: begin
        if (rem_q >= {14'd0, dsh_q}) begin
          rem_q <= rem_q - {14'd0, dsh_q};
          quo_q <= {quo_q[13:0], 1'b1};
        end else begin
          quo_q <= {quo_q[13:0], 1'b0};
        end
        dsh_q <= {1'b0, dsh_q[45:1]};
      end
      ST_FIN: begin
        if (out_free) begin
          out_q <= res;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign noise_value_o = out_q;

  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_i == MODE_LOAD)) |=> (state_q == ST_IDLE))
    else $error("load item started an evaluation");

  a_octave_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (k_q <= n_q))
    else $error("octave counter passed the octave count");

  a_div_needs_octaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (n_q != 4'd0))
    else $error("division started with zero octaves");

  a_fin_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FIN) && out_free) |=> (out_valid_q && (state_q == ST_IDLE)))
    else $error("finished item did not reach the output register");

endmodule
